@@ sv/pwt_pkg.sv @@
// ----------------------------------------------------------------------------
// pwt_pkg: shared types and constants of the pressure window trend block
// Field widths, history depth, the sample word type and cell controls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwt_pkg;

   // history depth and derived widths
   localparam int unsigned HISTORY_DEPTH = 64;
   localparam int unsigned DEPTH_W       = $clog2(HISTORY_DEPTH);
   localparam int unsigned CNT_W         = $clog2(HISTORY_DEPTH + 1);

   // field widths
   localparam int unsigned PRESS_W = 18;
   localparam int unsigned TIME_W  = 17;
   localparam int unsigned TREND_W = 19;
   localparam int unsigned MATCH_W = 7;
   localparam int unsigned AGE_W   = 19;

   // accumulator and divider widths
   localparam int unsigned MAG_W = PRESS_W + CNT_W;
   localparam int unsigned SUM_W = MAG_W + 1;

   // stream word widths
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 32;

   // time and window constants
   localparam logic [AGE_W-1:0] DAY_SECONDS = AGE_W'(86400);
   localparam logic [AGE_W-1:0] WINDOW_SPAN = AGE_W'(10);
   localparam logic [CNT_W-1:0] MIN_SAMPLES = CNT_W'(5);
   localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(3600);

   // function codes carried in tuser
   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // one held sample
   typedef struct packed {
      logic [PRESS_W-1:0] pressure;
      logic [TIME_W-1:0]  stamp;
   } sample_type;

   // per-cycle control shared by all cells
   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ sv/pwt_cell.sv @@
// ----------------------------------------------------------------------------
// pwt_cell: one history cell
// Holds one sample; loads from the newer-side neighbor on a record shift
// or from the older-side neighbor while the ring rotates during a scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwt_cell (
   input  wire                    clock,
   input  pwt_pkg::cell_ctrl_type ctrl,
   input  pwt_pkg::sample_type    shift_in,
   input  pwt_pkg::sample_type    rot_in,
   output pwt_pkg::sample_type    sample_q
);

   pwt_pkg::sample_type data_ff;

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      priority if (ctrl.shift) begin
         data_ff <= shift_in;
      end else if (ctrl.rotate) begin
         data_ff <= rot_in;
      end else begin
         data_ff <= data_ff;
      end
   end

   assign sample_q = data_ff;

endmodule

`default_nettype wire

@@ sv/pwt_divider.sv @@
// ----------------------------------------------------------------------------
// pwt_divider: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwt_divider (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [pwt_pkg::MAG_W-1:0]     dividend,
   input  wire [pwt_pkg::CNT_W-1:0]     divisor,
   output logic                         done,
   output logic [pwt_pkg::MAG_W-1:0]    quotient
);

   localparam int unsigned STEP_W = $clog2(pwt_pkg::MAG_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [pwt_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [pwt_pkg::CNT_W-1:0]   div_ff, div_in;
   logic [pwt_pkg::MAG_W-1:0]   quo_ff, quo_in;
   logic [pwt_pkg::CNT_W:0]     rem_shift;
   logic [pwt_pkg::CNT_W:0]     rem_diff;
   logic                        fits;

   // trial subtract of the shifted remainder
   assign rem_shift = {rem_ff, quo_ff[pwt_pkg::MAG_W-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign fits      = (rem_shift >= {1'b0, div_ff});

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff[pwt_pkg::CNT_W-1:0] : rem_shift[pwt_pkg::CNT_W-1:0];
         quo_in  = {quo_ff[pwt_pkg::MAG_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(pwt_pkg::MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ sv/pressure_window_trend_top.sv @@
// ----------------------------------------------------------------------------
// pressure_window_trend_top: pressure trend over a time-of-day window
// A row of history cells holds the latest samples, newest in cell 0.
// A query rotates the row once past an accumulator, then divides serially if any sample matched.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | contents
//  req     | in        | tvalid / tready  | tuser func, tdata pressure, time
//  rsp     | out       | tvalid / tready  | tdata trend, matched count
//  csr     | in        | we               | wdata window_seconds
//
//  a record word keeps the block in idle, so it is ready again at once
//  a query word passes through the scan of every cell, a launch state,
//  the serial divider and a hand-off state; a query with no match skips
//  the divider, and one taken with fewer than five samples held leaves
//  the block in idle at once and gives no word
//  reset is synchronous; it empties the history and loads window 3600
//  the hand-off state holds while the previous word still waits on rsp;
//  record and query words are taken while a word waits on rsp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pressure_window_trend_top (
   input  wire                              clock,
   input  wire                              reset,
   // configuration
   input  wire                              csr_we,
   input  wire [pwt_pkg::TIME_W-1:0]        csr_wdata,      // window_seconds
   // request stream
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire                              req_tuser,      // func
   input  wire [pwt_pkg::REQ_DATA_W-1:0]    req_tdata,      // pressure[17:0], time[34:18]
   // response stream
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [pwt_pkg::RSP_DATA_W-1:0]   rsp_tdata       // trend[18:0], count[25:19]
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_LAUNCH = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [pwt_pkg::TIME_W-1:0]      window_ff;
   logic [pwt_pkg::CNT_W-1:0]       fill_ff, fill_in;
   logic [pwt_pkg::DEPTH_W-1:0]     step_ff, step_in;
   logic [pwt_pkg::TIME_W-1:0]      now_ff, now_in;
   logic [pwt_pkg::PRESS_W-1:0]     pnew_ff, pnew_in;
   logic signed [pwt_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [pwt_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [pwt_pkg::TREND_W-1:0]     res_trend_ff, res_trend_in;
   logic [pwt_pkg::MATCH_W-1:0]     res_count_ff, res_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pwt_pkg::TREND_W-1:0]     rsp_trend_ff, rsp_trend_in;
   logic [pwt_pkg::MATCH_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                            req_acc;
   logic                            rsp_acc;
   pwt_pkg::sample_type             new_sample;
   pwt_pkg::sample_type             cell_q [pwt_pkg::HISTORY_DEPTH];
   pwt_pkg::cell_ctrl_type          cell_ctrl;

   logic [pwt_pkg::AGE_W-1:0]       now_w, then_w, now_wrap, age;
   logic [pwt_pkg::AGE_W-1:0]       lo_w, hi_w;
   logic                            age_ok, match;
   logic signed [pwt_pkg::SUM_W-1:0] diff;
   logic signed [pwt_pkg::SUM_W-1:0] sum_neg;
   logic [pwt_pkg::MAG_W-1:0]       mag;
   logic                            div_start, div_done;
   logic [pwt_pkg::MAG_W-1:0]       quotient;
   logic signed [pwt_pkg::SUM_W-1:0] quo_s;
   logic signed [pwt_pkg::SUM_W-1:0] trend_s;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_valid_ff && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign new_sample.pressure = req_tdata[pwt_pkg::PRESS_W-1:0];
   assign new_sample.stamp    = req_tdata[pwt_pkg::PRESS_W +: pwt_pkg::TIME_W];

   // cell controls shared along the row
   assign cell_ctrl.shift  = req_acc && (req_tuser == pwt_pkg::FUNC_RECORD);
   assign cell_ctrl.rotate = (state_ff == ST_SCAN);

   // row of history cells, newest in cell 0
   for (genvar k = 0; k < pwt_pkg::HISTORY_DEPTH; k++) begin : g_cell
      localparam int unsigned NEXT = (k + 1) % pwt_pkg::HISTORY_DEPTH;
      pwt_pkg::sample_type shift_src;
      if (k == 0) begin : g_head
         assign shift_src = new_sample;
      end else begin : g_body
         assign shift_src = cell_q[k-1];
      end
      pwt_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .shift_in (shift_src),
         .rot_in   (cell_q[NEXT]),
         .sample_q (cell_q[k])
      );
   end

   // age of the sample at the head of the row, wrapping over midnight
   assign now_w    = pwt_pkg::AGE_W'(now_ff);
   assign then_w   = pwt_pkg::AGE_W'(cell_q[0].stamp);
   assign now_wrap = now_w + pwt_pkg::DAY_SECONDS;
   always_comb begin
      if (now_w >= then_w) begin
         age    = now_w - then_w;
         age_ok = 1'b1;
      end else begin
         age    = now_wrap - then_w;
         age_ok = (now_wrap >= then_w);
      end
   end

   // window test, limited to held entries
   assign lo_w  = pwt_pkg::AGE_W'(window_ff);
   assign hi_w  = lo_w + pwt_pkg::WINDOW_SPAN;
   assign match = age_ok && (age >= lo_w) && (age < hi_w)
                  && (pwt_pkg::CNT_W'(step_ff) < fill_ff);
   assign diff  = $signed(pwt_pkg::SUM_W'(pnew_ff)) - $signed(pwt_pkg::SUM_W'(cell_q[0].pressure));

   // magnitude for the divider, sign applied afterwards
   assign sum_neg = -sum_ff;
   assign mag     = sum_ff[pwt_pkg::SUM_W-1] ? sum_neg[pwt_pkg::MAG_W-1:0]
                                             : sum_ff[pwt_pkg::MAG_W-1:0];
   assign quo_s   = $signed({1'b0, quotient});
   assign trend_s = sum_ff[pwt_pkg::SUM_W-1] ? -quo_s : quo_s;
   assign div_start = (state_ff == ST_LAUNCH) && (cnt_ff != '0);

   pwt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // sequencer and accumulator
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      step_in      = step_ff;
      now_in       = now_ff;
      pnew_in      = pnew_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      res_trend_in = res_trend_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_acc;
      rsp_trend_in = rsp_trend_ff;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cell_ctrl.shift) begin
               if (fill_ff != pwt_pkg::CNT_W'(pwt_pkg::HISTORY_DEPTH)) begin
                  fill_in = fill_ff + pwt_pkg::CNT_W'(1);
               end
            end else if (req_acc && (fill_ff >= pwt_pkg::MIN_SAMPLES)) begin
               now_in   = new_sample.stamp;
               pnew_in  = cell_q[0].pressure;
               sum_in   = '0;
               cnt_in   = '0;
               step_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               sum_in = sum_ff + diff;
               cnt_in = cnt_ff + pwt_pkg::CNT_W'(1);
            end
            step_in = step_ff + pwt_pkg::DEPTH_W'(1);
            if (step_ff == pwt_pkg::DEPTH_W'(pwt_pkg::HISTORY_DEPTH - 1)) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            if (cnt_ff == '0) begin
               res_trend_in = '0;
               res_count_in = '0;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_trend_in = trend_s[pwt_pkg::TREND_W-1:0];
               res_count_in = pwt_pkg::MATCH_W'(cnt_ff);
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_acc) begin
               rsp_valid_in = 1'b1;
               rsp_trend_in = res_trend_ff;
               rsp_count_in = res_count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         window_ff    <= pwt_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      now_ff       <= now_in;
      pnew_ff      <= pnew_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      res_trend_ff <= res_trend_in;
      res_count_ff <= res_count_in;
      rsp_trend_ff <= rsp_trend_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pwt_pkg::RSP_DATA_W - pwt_pkg::TREND_W - pwt_pkg::MATCH_W){1'b0}},
                        rsp_count_ff, rsp_trend_ff};

endmodule

`default_nettype wire

@@ sv/pwt_checker.sv @@
// ----------------------------------------------------------------------------
// pwt_checker: port-level checks of the pressure window trend block
// Watches the top level's ports and flags results that break its rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwt_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [pwt_pkg::TIME_W-1:0]        csr_wdata,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   input  wire                              req_tuser,
   input  wire [pwt_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire [pwt_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int unsigned CNT_LO = pwt_pkg::TREND_W;
   localparam int unsigned CNT_HI = pwt_pkg::TREND_W + pwt_pkg::MATCH_W - 1;

   // stalled response word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   // a record word never blocks the next word
   a_record_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == pwt_pkg::FUNC_RECORD) |=> req_tready)
      else $error("record word left request side stalled");

   // a new response only comes out of a running query
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response word without a query in flight");

   // match count never exceeds the history depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CNT_HI:CNT_LO]
                      <= pwt_pkg::MATCH_W'(pwt_pkg::HISTORY_DEPTH)))
      else $error("match count above history depth");

   // no match gives a zero trend
   a_zero_trend: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[CNT_HI:CNT_LO] == '0) |->
         (rsp_tdata[pwt_pkg::TREND_W-1:0] == '0))
      else $error("nonzero trend with no matched samples");

   logic unused_ok;
   assign unused_ok = csr_we ^ (^csr_wdata) ^ (^req_tdata);

endmodule

bind pressure_window_trend_top pwt_checker u_pwt_checker (.*);

`default_nettype wire
